>>> rtl/kect_pkg.sv
package kect_pkg;

  // Table geometry.
  localparam int ENTRIES = 24;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 5;
  localparam int WIDE_W  = IDX_W + SLOT_W;
  localparam int DATA_W  = 32;

  localparam logic [DATA_W-1:0] CNT_MAX = '1;

  // Command codes carried by an input item.
  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  // Which kind of result the datapath captures.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_READ,
    EMIT_RECORD,
    EMIT_DROP
  } emit_e;

  typedef struct packed {
    cmd_e              command;
    logic [DATA_W-1:0] notice_interface;
    logic [DATA_W-1:0] notice_type;
    logic [SLOT_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic              entry_used;
    logic [DATA_W-1:0] entry_interface;
    logic [DATA_W-1:0] entry_type;
    logic [DATA_W-1:0] entry_count;
    logic [SLOT_W-1:0] entry_slot;
    logic              dropped;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic [DATA_W-1:0] key_interface;
    logic [DATA_W-1:0] key_type;
    logic [DATA_W-1:0] event_count;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic  load;
    logic  step;
    emit_e emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic last;
  } dp_status_t;

endpackage

>>> rtl/kect_datapath.sv
module kect_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kect_pkg::in_item_t   req_i,
  input  kect_pkg::dp_cmd_t    cmd_i,
  output kect_pkg::dp_status_t status_o,
  output kect_pkg::out_item_t  res_o
);
  import kect_pkg::*;

  in_item_t          item_q;
  logic              in_range_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ENTRIES-1:0] valid_q;
  entry_t            mem [ENTRIES];
  entry_t            rdata_q;
  entry_t            wdata;
  out_item_t         res_q, res_d;

  logic [WIDE_W-1:0] rd_wide;
  logic [WIDE_W-1:0] idx_wide;
  logic              rd_in_range;
  logic              cur_valid;
  logic              key_match;
  logic [DATA_W-1:0] cnt_new;

  // Decode the requested read index against the table size.
  assign rd_wide     = WIDE_W'(req_i.read_index);
  assign rd_in_range = rd_wide < WIDE_W'(ENTRIES);
  assign idx_wide    = WIDE_W'(idx_q);

  // Next scan index: load at start, advance while scanning.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      if (req_i.command == CMD_READ && rd_in_range) begin
        idx_d = rd_wide[IDX_W-1:0];
      end else begin
        idx_d = '0;
      end
    end else if (cmd_i.step) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Captured item; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= req_i;
      in_range_q <= rd_in_range;
    end
  end

  // Entry is in use once it has been written; reset empties the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.emit == EMIT_RECORD) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // Compare the entry under the scan index and form the updated count.
  assign cur_valid = valid_q[idx_q];
  assign key_match = (rdata_q.key_interface == item_q.notice_interface) &&
                     (rdata_q.key_type == item_q.notice_type);

  always_comb begin
    if (!cur_valid) begin
      cnt_new = DATA_W'(1);
    end else if (rdata_q.event_count == CNT_MAX) begin
      cnt_new = rdata_q.event_count;
    end else begin
      cnt_new = rdata_q.event_count + DATA_W'(1);
    end
  end

  assign wdata.key_interface = item_q.notice_interface;
  assign wdata.key_type      = item_q.notice_type;
  assign wdata.event_count   = cnt_new;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit == EMIT_RECORD) begin
      mem[idx_q] <= wdata;
    end
    rdata_q <= mem[idx_d];
  end

  assign status_o.hit  = !cur_valid || key_match;
  assign status_o.last = idx_q == IDX_W'(ENTRIES - 1);

  // Result formatting for each kind of completion.
  always_comb begin
    res_d = res_q;
    case (cmd_i.emit)
      EMIT_READ: begin
        res_d            = '0;
        res_d.entry_slot = item_q.read_index;
        if (in_range_q && cur_valid) begin
          res_d.entry_used      = 1'b1;
          res_d.entry_interface = rdata_q.key_interface;
          res_d.entry_type      = rdata_q.key_type;
          res_d.entry_count     = rdata_q.event_count;
        end
      end
      EMIT_RECORD: begin
        res_d.entry_used      = 1'b1;
        res_d.entry_interface = item_q.notice_interface;
        res_d.entry_type      = item_q.notice_type;
        res_d.entry_count     = cnt_new;
        res_d.entry_slot      = idx_wide[SLOT_W-1:0];
        res_d.dropped         = 1'b0;
      end
      EMIT_DROP: begin
        res_d         = '0;
        res_d.dropped = 1'b1;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/kect_ctrl.sv
module kect_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 cmd_read_i,
  input  kect_pkg::dp_status_t status_i,
  output kect_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import kect_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Sequencing: a read does a single lookup, a record walks the table.
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    cmd_o.emit = EMIT_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = cmd_read_i ? ST_READ : ST_SCAN;
        end
      end
      ST_READ: begin
        cmd_o.emit = EMIT_READ;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.emit = EMIT_RECORD;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else if (status_i.last) begin
          cmd_o.emit = EMIT_DROP;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;

endmodule

>>> rtl/keyed_event_count_table_top.sv
// Keyed event count table: ENTRIES entries of (interface, type, count).
// Input channel: an item (req_i) is taken at a rising edge where start is
// high and busy is low. A record item scans the entries from index 0 and
// bumps the first entry that is empty or holds the same interface and type;
// a read item returns the entry named by read_index.
// Output channel: each item yields exactly one result on res_o, marked by
// done_o for a single cycle. The receiver cannot stall; it must take the
// result in that cycle.
// Sequence: after the accept edge, a read does a single lookup and a
// record visits one entry per cycle, from index 0 up to its slot (all
// ENTRIES when the table is full and the item is dropped). The result
// strobe follows in the next cycle, in which a new item may already be
// started. One read port is the limit: lookups of two items never overlap.
// Reset empties the table at once (per-entry valid bits) and returns the
// sequencer to idle; no clearing pass is needed.
module keyed_event_count_table_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kect_pkg::in_item_t  req_i,
  output logic                done_o,
  output kect_pkg::out_item_t res_o
);
  import kect_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       cmd_read;

  assign cmd_read = req_i.command == CMD_READ;

  kect_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_read_i (cmd_read),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  kect_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (dp_cmd),
    .status_o (dp_status),
    .res_o    (res_o)
  );

  // A result is only presented once the sequencer is back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always occupies the sequencer in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("item accepted but sequencer stayed idle");

  // A dropped record reports an empty entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.dropped) |-> (!res_o.entry_used && res_o.entry_count == '0))
    else $error("dropped result carries entry data");

  // A used entry never shows a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.entry_used) |-> (res_o.entry_count != '0))
    else $error("used entry with zero count");

endmodule

>>> verif/keyed_event_count_table_top_test.sv
`timescale 1ns / 1ps

module keyed_event_count_table_top_test;
  import kect_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 34;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  req_i;
  logic      done_o;
  out_item_t res_o;

  // Shadow copy of the table, updated as each item is accepted.
  logic [DATA_W-1:0] shadow_ifc   [ENTRIES];
  logic [DATA_W-1:0] shadow_type  [ENTRIES];
  logic [DATA_W-1:0] shadow_count [ENTRIES];

  // Results predicted but not yet seen on the result port.
  out_item_t pending_entries[$];

  // Keys that random records draw from, so that entries match and the table fills.
  logic [DATA_W-1:0] pool_ifc  [POOL_SIZE];
  logic [DATA_W-1:0] pool_type [POOL_SIZE];

  int errors;
  int cycles;
  int idle_pct;
  int n_records;
  int n_reads;
  int n_drops;
  int n_repeats;
  int n_far_reads;

  keyed_event_count_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_entries.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Works out the result of one item and applies it to the shadow table.
  function automatic out_item_t table_result(input in_item_t it);
    out_item_t r;
    int        slot;
    int        i;
    r = '0;
    if (it.command == CMD_READ) begin
      n_reads++;
      r.entry_slot = it.read_index;
      if (it.read_index >= ENTRIES) begin
        n_far_reads++;
      end else if (shadow_count[it.read_index] != '0) begin
        r.entry_used      = 1'b1;
        r.entry_interface = shadow_ifc[it.read_index];
        r.entry_type      = shadow_type[it.read_index];
        r.entry_count     = shadow_count[it.read_index];
      end
      return r;
    end
    n_records++;
    // The first entry that is empty or holds the same key wins.
    slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && (shadow_count[i] == '0 ||
          (shadow_ifc[i] == it.notice_interface && shadow_type[i] == it.notice_type))) begin
        slot = i;
      end
    end
    if (slot < 0) begin
      n_drops++;
      r.dropped = 1'b1;
      return r;
    end
    if (shadow_count[slot] != '0) n_repeats++;
    shadow_ifc[slot]  = it.notice_interface;
    shadow_type[slot] = it.notice_type;
    if (shadow_count[slot] != CNT_MAX) shadow_count[slot] = shadow_count[slot] + 1;
    r.entry_used      = 1'b1;
    r.entry_interface = shadow_ifc[slot];
    r.entry_type      = shadow_type[slot];
    r.entry_count     = shadow_count[slot];
    r.entry_slot      = SLOT_W'(slot);
    return r;
  endfunction

  function automatic in_item_t make_item(input cmd_e cmd, input logic [DATA_W-1:0] ifc,
                                         input logic [DATA_W-1:0] typ,
                                         input logic [SLOT_W-1:0] idx);
    in_item_t it;
    it.command          = cmd;
    it.notice_interface = ifc;
    it.notice_type      = typ;
    it.read_index       = idx;
    return it;
  endfunction

  // Number of idle cycles before the next item; now and then a long one.
  function automatic int pick_gap();
    int g;
    g = 0;
    if (idle_pct == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(1, 40);
    while ($urandom_range(0, 99) < idle_pct) g++;
    return g;
  endfunction

  // Presents one item and returns at the edge that accepts it.
  task automatic issue_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    do @(posedge clk_i); while (busy);
    pending_entries.push_back(table_result(it));
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Each strobed result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      if (pending_entries.size() == 0) begin
        $error("Result with no item outstanding (slot %0d)", res_o.entry_slot);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        check_field("entry_used", DATA_W'(want.entry_used), DATA_W'(res_o.entry_used));
        check_field("entry_interface", want.entry_interface, res_o.entry_interface);
        check_field("entry_type", want.entry_type, res_o.entry_type);
        check_field("entry_count", want.entry_count, res_o.entry_count);
        check_field("entry_slot", DATA_W'(want.entry_slot), DATA_W'(res_o.entry_slot));
        check_field("dropped", DATA_W'(want.dropped), DATA_W'(res_o.dropped));
      end
    end
  end

  // Reads of a fresh table, including indexes past the last entry.
  task automatic test_empty_reads();
    issue_item(make_item(CMD_READ, '0, '0, 5'd0));
    issue_item(make_item(CMD_READ, '0, '0, 5'(ENTRIES - 1)));
    issue_item(make_item(CMD_READ, '0, '0, 5'(ENTRIES)));
    issue_item(make_item(CMD_READ, '1, '1, 5'd31));
  endtask

  // Records with extreme keys, a repeat, and keys that match in one half only.
  task automatic test_record_keys();
    issue_item(make_item(CMD_RECORD, '0, '0, 5'd31));
    issue_item(make_item(CMD_RECORD, '1, '1, 5'd0));
    issue_item(make_item(CMD_RECORD, '0, '0, 5'($urandom)));
    issue_item(make_item(CMD_RECORD, '0, '1, 5'($urandom)));
    issue_item(make_item(CMD_RECORD, '1, '0, 5'($urandom)));
    issue_item(make_item(CMD_RECORD, '1, '1, 5'($urandom)));
    issue_item(make_item(CMD_RECORD, '0, '0, 5'($urandom)));
  endtask

  // Reads of the entries just written and of the first one still empty.
  task automatic test_read_back();
    int i;
    for (i = 0; i < 5; i++) begin
      issue_item(make_item(CMD_READ, $urandom, $urandom, 5'(i)));
    end
  endtask

  // Mixed records and reads; most records reuse pool keys, the rest are fresh.
  task automatic test_random_traffic(input int n_items, input int pct);
    in_item_t it;
    int       k;
    int       n;
    idle_pct = pct;
    for (n = 0; n < n_items; n++) begin
      it = make_item(CMD_RECORD, $urandom, $urandom, 5'($urandom_range(0, 31)));
      if ($urandom_range(0, 99) < 35) begin
        it.command = CMD_READ;
        if ($urandom_range(0, 99) < 15) it.read_index = 5'($urandom_range(ENTRIES, 31));
        else it.read_index = 5'($urandom_range(0, ENTRIES - 1));
      end else if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        it.notice_interface = pool_ifc[k];
        it.notice_type      = pool_type[k];
      end
      issue_item(it);
    end
  endtask

  initial begin
    int i;
    idle_pct    = 0;
    n_records   = 0;
    n_reads     = 0;
    n_drops     = 0;
    n_repeats   = 0;
    n_far_reads = 0;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_ifc[i]   = '0;
      shadow_type[i]  = '0;
      shadow_count[i] = '0;
    end
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_record_keys();
    test_read_back();

    // Pool keys: the directed ones, random ones, and some sharing an interface.
    pool_ifc[0] = '0; pool_type[0] = '0;
    pool_ifc[1] = '1; pool_type[1] = '1;
    pool_ifc[2] = '0; pool_type[2] = '1;
    pool_ifc[3] = '1; pool_type[3] = '0;
    for (i = 4; i < POOL_SIZE; i++) begin
      pool_ifc[i]  = ($urandom_range(0, 3) == 0) ? pool_ifc[$urandom_range(0, i - 1)] : $urandom;
      pool_type[i] = $urandom;
    end

    test_random_traffic(300, 0);
    test_random_traffic(350, 71);
    test_random_traffic(350, 24);

    // Drain outstanding results, then watch for stray strobes.
    start <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d records (%0d onto existing keys, %0d dropped on a full table)",
             n_records, n_repeats, n_drops);
    $display("and %0d reads (%0d past the last entry) in %0d cycles", n_reads, n_far_reads,
             cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
